// ----- hdl/xbr_pkg.sv -----
// shared types, character codes and helpers for the block receiver
// no dependencies; imported by every module of the receiver
`default_nettype none

package xbr_pkg;

  // block sizes in bytes
  localparam int SMALL_BLOCK_BYTES = 128;
  localparam int LARGE_BLOCK_BYTES = 1024;
  localparam int POS_W             = 11;
  localparam int SIZE_W            = POS_W + 1;

  // serial control characters
  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CAN = 8'h18;
  localparam logic [7:0] CH_C   = 8'h43;
  localparam logic [7:0] CH_G   = 8'h47;

  // input commands
  localparam logic [1:0] CMD_BYTE  = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  // protocol modes
  localparam logic [1:0] MODE_X = 2'd0;
  localparam logic [1:0] MODE_G = 2'd2;

  // event codes
  localparam logic [3:0] EV_NONE     = 4'd0;
  localparam logic [3:0] EV_OK       = 4'd1;
  localparam logic [3:0] EV_NUM_BAD  = 4'd2;
  localparam logic [3:0] EV_CHK_BAD  = 4'd3;
  localparam logic [3:0] EV_TIMEOUT  = 4'd4;
  localparam logic [3:0] EV_CANCEL   = 4'd5;
  localparam logic [3:0] EV_EOT      = 4'd6;
  localparam logic [3:0] EV_FALLBACK = 4'd7;
  localparam logic [3:0] EV_GAVE_UP  = 4'd8;
  localparam logic [3:0] EV_G_ABORT  = 4'd9;
  localparam logic [3:0] EV_HEADER   = 4'd10;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LARGE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHECKSUM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WAIT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ATTEMPTS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FALLBACK = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CANCEL   = 3'd6;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] rx_byte;
    logic [7:0] first_block;
  } in_item_t;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       payload_last;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [3:0] event_res;
    logic       crc_mode;
    logic       large_block;
  } out_item_t;

  typedef struct packed {
    logic [1:0] protocol_mode;
    logic       request_large_blocks;
    logic       prefer_checksum;
    logic [3:0] wait_seconds;
    logic [3:0] max_attempts;
    logic [3:0] fallback_attempt;
    logic [2:0] cancel_limit;
  } cfg_t;

  // one byte of CRC-16, polynomial 0x1021, msb first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/xbr_cfg.sv -----
// configuration register file of the block receiver
// depends on xbr_pkg
`default_nettype none

module xbr_cfg (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           cfg_we,
  input  wire [xbr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [xbr_pkg::CFG_DAT_W-1:0]  cfg_wdata,
  output xbr_pkg::cfg_t                 cfg
);
  import xbr_pkg::*;

  cfg_t cfg_r;

  // register writes, indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.protocol_mode        <= 2'd0;
      cfg_r.request_large_blocks <= 1'b0;
      cfg_r.prefer_checksum      <= 1'b0;
      cfg_r.wait_seconds         <= 4'd5;
      cfg_r.max_attempts         <= 4'd12;
      cfg_r.fallback_attempt     <= 4'd4;
      cfg_r.cancel_limit         <= 3'd5;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:     cfg_r.protocol_mode        <= cfg_wdata[1:0];
        REG_LARGE:    cfg_r.request_large_blocks <= cfg_wdata[0];
        REG_CHECKSUM: cfg_r.prefer_checksum      <= cfg_wdata[0];
        REG_WAIT:     cfg_r.wait_seconds         <= cfg_wdata;
        REG_ATTEMPTS: cfg_r.max_attempts         <= cfg_wdata;
        REG_FALLBACK: cfg_r.fallback_attempt     <= cfg_wdata;
        REG_CANCEL:   cfg_r.cancel_limit         <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ----- hdl/xbr_step.sv -----
// protocol state machine: one item per cycle while fire is high, state and result register
// depends on xbr_pkg
`default_nettype none

module xbr_step (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    fire,
  input  wire xbr_pkg::in_item_t item,
  input  wire xbr_pkg::cfg_t     cfg,
  output xbr_pkg::out_item_t     res
);
  import xbr_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_SHAKE = 2'd1,
    PH_BLOCK = 2'd2,
    PH_WAIT  = 2'd3
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             large_r, large_nxt;
  logic             crc_r, crc_nxt;
  logic [15:0]      run_r, run_nxt;
  logic [7:0]       exp_r, exp_nxt;
  logic [7:0]       num_r, num_nxt;
  logic [7:0]       cmp_r, cmp_nxt;
  logic [15:0]      chk_r, chk_nxt;
  logic [3:0]       sec_r, sec_nxt;
  logic [3:0]       att_r, att_nxt;
  logic [2:0]       can_r, can_nxt;
  logic [7:0]       req_r, req_nxt;
  out_item_t        res_r, res_nxt;

  logic [7:0]        pick;
  logic [SIZE_W-1:0] size;
  logic [SIZE_W-1:0] pos_ext;
  logic [SIZE_W-1:0] pos_inc;
  logic [SIZE_W-1:0] total;
  logic [3:0]        sec_inc;
  logic [3:0]        att_inc;
  logic [2:0]        can_inc;
  logic              ok_num;
  logic              ok_chk;
  logic [7:0]        b;

  // handshake character for the configured mode
  always_comb begin
    if (cfg.protocol_mode == MODE_G) begin
      pick = CH_G;
    end else if (cfg.protocol_mode == MODE_X) begin
      if (cfg.request_large_blocks) begin
        pick = cfg.prefer_checksum ? CH_NAK : CH_C;
      end else begin
        pick = cfg.prefer_checksum ? CH_C : CH_NAK;
      end
    end else begin
      pick = cfg.prefer_checksum ? CH_NAK : CH_C;
    end
  end

  // block geometry and saturating counters
  assign b       = item.rx_byte;
  assign size    = large_r ? SIZE_W'(LARGE_BLOCK_BYTES) : SIZE_W'(SMALL_BLOCK_BYTES);
  assign pos_ext = {1'b0, pos_r};
  assign pos_inc = pos_ext + 1'b1;
  assign total   = size + (crc_r ? SIZE_W'(4) : SIZE_W'(3));
  assign sec_inc = (sec_r == 4'd15) ? sec_r : sec_r + 1'b1;
  assign att_inc = (att_r == 4'd15) ? att_r : att_r + 1'b1;
  assign can_inc = (can_r == 3'd7) ? can_r : can_r + 1'b1;

  // next state and result for the current item
  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    large_nxt = large_r;
    crc_nxt   = crc_r;
    run_nxt   = run_r;
    exp_nxt   = exp_r;
    num_nxt   = num_r;
    cmp_nxt   = cmp_r;
    chk_nxt   = chk_r;
    sec_nxt   = sec_r;
    att_nxt   = att_r;
    can_nxt   = can_r;
    req_nxt   = req_r;
    res_nxt   = '0;
    ok_num    = 1'b0;
    ok_chk    = 1'b0;

    case (item.cmd)
      CMD_START: begin
        req_nxt   = pick;
        exp_nxt   = item.first_block;
        att_nxt   = 4'd0;
        sec_nxt   = 4'd0;
        can_nxt   = 3'd0;
        phase_nxt = PH_SHAKE;
        res_nxt.tx_valid = 1'b1;
        res_nxt.tx_byte  = pick;
      end
      CMD_BYTE: begin
        if (phase_r == PH_SHAKE || phase_r == PH_WAIT) begin
          if (b == CH_SOH || b == CH_STX) begin
            if (phase_r == PH_SHAKE) crc_nxt = (req_r != CH_NAK);
            large_nxt = (b == CH_STX);
            pos_nxt   = '0;
            run_nxt   = 16'd0;
            chk_nxt   = 16'd0;
            sec_nxt   = 4'd0;
            can_nxt   = 3'd0;
            phase_nxt = PH_BLOCK;
            res_nxt.event_res = EV_HEADER;
          end else if (b == CH_EOT) begin
            if (phase_r == PH_SHAKE) crc_nxt = (req_r != CH_NAK);
            can_nxt   = 3'd0;
            phase_nxt = PH_IDLE;
            res_nxt.tx_valid  = 1'b1;
            res_nxt.tx_byte   = CH_ACK;
            res_nxt.event_res = EV_EOT;
          end else if (b == CH_CAN) begin
            can_nxt = can_inc;
            if (can_inc >= cfg.cancel_limit) begin
              phase_nxt = PH_IDLE;
              res_nxt.event_res = EV_CANCEL;
            end
          end else begin
            can_nxt = 3'd0;
          end
        end else if (phase_r == PH_BLOCK) begin
          // number, complement, data, then check bytes
          if (pos_ext == '0) begin
            num_nxt = b;
          end else if (pos_ext == SIZE_W'(1)) begin
            cmp_nxt = b;
          end else if (pos_ext < size + SIZE_W'(2)) begin
            res_nxt.payload_valid = 1'b1;
            res_nxt.payload_byte  = b;
            res_nxt.payload_last  = (pos_ext == size + SIZE_W'(1));
            run_nxt = crc_r ? crc16_byte(run_r, b) : {8'h00, run_r[7:0] + b};
          end else begin
            chk_nxt = {chk_r[7:0], b};
          end
          pos_nxt = pos_inc[POS_W-1:0];
          // end of block verdict
          if (pos_inc >= total) begin
            ok_num = (num_nxt == exp_r) && (cmp_nxt == ~exp_r);
            ok_chk = crc_r ? (chk_nxt == run_nxt) : (chk_nxt[7:0] == run_nxt[7:0]);
            sec_nxt = 4'd0;
            att_nxt = 4'd0;
            can_nxt = 3'd0;
            if (ok_num && ok_chk) begin
              if (cfg.protocol_mode != MODE_G) begin
                res_nxt.tx_valid = 1'b1;
                res_nxt.tx_byte  = CH_ACK;
              end
              exp_nxt   = exp_r + 1'b1;
              phase_nxt = PH_WAIT;
              res_nxt.event_res = EV_OK;
            end else if (cfg.protocol_mode == MODE_G) begin
              phase_nxt = PH_IDLE;
              res_nxt.event_res = EV_G_ABORT;
            end else begin
              res_nxt.tx_valid  = 1'b1;
              res_nxt.tx_byte   = CH_NAK;
              phase_nxt         = PH_WAIT;
              res_nxt.event_res = ok_num ? EV_CHK_BAD : EV_NUM_BAD;
            end
          end
        end
      end
      CMD_TICK: begin
        if (phase_r == PH_BLOCK) begin
          // block timeout counted from the header
          sec_nxt = sec_inc;
          if (sec_inc >= cfg.wait_seconds) begin
            sec_nxt = 4'd0;
            att_nxt = 4'd0;
            can_nxt = 3'd0;
            if (cfg.protocol_mode == MODE_G) begin
              phase_nxt = PH_IDLE;
              res_nxt.event_res = EV_G_ABORT;
            end else begin
              res_nxt.tx_valid  = 1'b1;
              res_nxt.tx_byte   = CH_NAK;
              phase_nxt         = PH_WAIT;
              res_nxt.event_res = EV_TIMEOUT;
            end
          end
        end else if (phase_r == PH_SHAKE || phase_r == PH_WAIT) begin
          // header wait timeout, resend or give up
          sec_nxt = sec_inc;
          if (sec_inc >= cfg.wait_seconds) begin
            sec_nxt = 4'd0;
            can_nxt = 3'd0;
            att_nxt = att_inc;
            if (att_inc >= cfg.max_attempts) begin
              phase_nxt = PH_IDLE;
              res_nxt.event_res = EV_GAVE_UP;
            end else if (phase_r == PH_SHAKE) begin
              res_nxt.event_res = EV_TIMEOUT;
              res_nxt.tx_valid  = 1'b1;
              res_nxt.tx_byte   = req_r;
              if (att_inc == cfg.fallback_attempt && cfg.protocol_mode != MODE_G &&
                  req_r == CH_C) begin
                req_nxt           = CH_NAK;
                res_nxt.tx_byte   = CH_NAK;
                res_nxt.event_res = EV_FALLBACK;
              end
            end else begin
              res_nxt.tx_valid  = 1'b1;
              res_nxt.tx_byte   = CH_NAK;
              res_nxt.event_res = EV_TIMEOUT;
            end
          end
        end
      end
      default: ;
    endcase

    res_nxt.crc_mode    = crc_nxt;
    res_nxt.large_block = large_nxt;
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pos_r   <= '0;
      large_r <= 1'b0;
      crc_r   <= 1'b0;
      run_r   <= 16'd0;
      exp_r   <= 8'd0;
      num_r   <= 8'd0;
      cmp_r   <= 8'd0;
      chk_r   <= 16'd0;
      sec_r   <= 4'd0;
      att_r   <= 4'd0;
      can_r   <= 3'd0;
      req_r   <= CH_NAK;
    end else if (fire) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      large_r <= large_nxt;
      crc_r   <= crc_nxt;
      run_r   <= run_nxt;
      exp_r   <= exp_nxt;
      num_r   <= num_nxt;
      cmp_r   <= cmp_nxt;
      chk_r   <= chk_nxt;
      sec_r   <= sec_nxt;
      att_r   <= att_nxt;
      can_r   <= can_nxt;
      req_r   <= req_nxt;
    end
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

// ----- hdl/xymodem_block_receiver_core.sv -----
// X/Y/G-modem block receiver: input register, protocol step, result register
// an accepted item passes through the input register, then the result register
// throughput: one item per cycle while the output is not stalled; the protocol step is a single pass of logic
// an item is held in the input register while the result register is stalled
// reset (rst_n low, synchronous) empties both registers, restores register
// defaults and puts the protocol in idle
`default_nettype none

module xymodem_block_receiver_core (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire xbr_pkg::in_item_t        in_data,
  output logic                          out_valid,
  input  wire                           out_stall,
  output xbr_pkg::out_item_t            out_data,
  input  wire                           cfg_we,
  input  wire [xbr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [xbr_pkg::CFG_DAT_W-1:0]  cfg_wdata
);
  import xbr_pkg::*;

  cfg_t     cfg;
  in_item_t in_item_r;
  logic     in_vld_r;
  logic     out_vld_r;
  logic     fire;

  // the held item moves on when the result register is free
  assign fire     = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !fire;

  // input register and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (!in_stall) in_vld_r <= in_valid;
      if (fire) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
    if (in_valid && !in_stall) begin
      in_item_r <= in_data;
    end
  end

  xbr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  xbr_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (in_item_r),
    .cfg   (cfg),
    .res   (out_data)
  );

  assign out_valid = out_vld_r;

endmodule

`default_nettype wire

// ----- hdl/xbr_checker.sv -----
// port-level checks for the block receiver, bound to the top level
// depends on xbr_pkg and xymodem_block_receiver_core
`default_nettype none

module xbr_checker (
  input wire                      clk,
  input wire                      rst_n,
  input wire                      out_valid,
  input wire                      out_stall,
  input wire xbr_pkg::out_item_t  out_data
);
  import xbr_pkg::*;

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // a data byte never comes with an answer or an event
  a_payload_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.payload_valid |->
      !out_data.tx_valid && out_data.event_res == EV_NONE)
    else $error("payload item carries tx byte or event");

  // only protocol characters are sent
  a_tx_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.tx_valid |->
      out_data.tx_byte == CH_ACK || out_data.tx_byte == CH_NAK ||
      out_data.tx_byte == CH_C || out_data.tx_byte == CH_G)
    else $error("unexpected tx byte");

  // unused payload fields read zero
  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.payload_valid |->
      out_data.payload_byte == 8'd0 && !out_data.payload_last)
    else $error("payload fields set without payload_valid");

  // nothing is shown right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind xymodem_block_receiver_core xbr_checker u_xbr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
